@@ rtl/stl_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stl_pkg
// Shared types, token kinds and keyword matching for the SQL token lexer.
// ---------------------------------------------------------------------------
package stl_pkg;

  localparam int MAX_WORD_LEN = 17;
  localparam int COUNT_BITS   = 16;
  localparam int KIND_BITS    = 7;
  localparam int WIDX_BITS    = $clog2(MAX_WORD_LEN);

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [KIND_BITS-1:0]  kind_t;
  typedef logic [7:0]            char_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_IDENT   = 3'd1,
    ST_NUMBER  = 3'd2,
    ST_STRING  = 3'd3,
    ST_HELD    = 3'd4,
    ST_COMMENT = 3'd5
  } scan_t;

  localparam kind_t K_EOF    = 7'd0;
  localparam kind_t K_UNK    = 7'd1;
  localparam kind_t K_IDENT  = 7'd2;
  localparam kind_t K_NUMBER = 7'd3;
  localparam kind_t K_STRING = 7'd4;
  localparam kind_t K_LPAREN = 7'd5;
  localparam kind_t K_RPAREN = 7'd6;
  localparam kind_t K_COMMA  = 7'd7;
  localparam kind_t K_SEMI   = 7'd8;
  localparam kind_t K_DOT    = 7'd9;
  localparam kind_t K_STAR   = 7'd10;
  localparam kind_t K_PCT    = 7'd11;
  localparam kind_t K_PLUS   = 7'd12;
  localparam kind_t K_MINUS  = 7'd13;
  localparam kind_t K_SLASH  = 7'd14;
  localparam kind_t K_EQ     = 7'd15;
  localparam kind_t K_LE     = 7'd16;
  localparam kind_t K_NE     = 7'd17;
  localparam kind_t K_LT     = 7'd18;
  localparam kind_t K_GE     = 7'd19;
  localparam kind_t K_GT     = 7'd20;

  typedef struct packed {
    logic  valid;
    kind_t kind;
    cnt_t  line;
    cnt_t  col;
    cnt_t  span;
  } rec_t;

  localparam int NUM_KW = 73;
  typedef logic [MAX_WORD_LEN*8-1:0] word_t;

  // keyword text, first character in the lowest byte, zero padded
  function automatic word_t kw_text(input int i);
    string s;
    string pfx;
    word_t w;
    s = "";
    pfx = "CURRENT_";
    w = '0;
    case (i)
      0: s = "SELECT";        1: s = "FROM";        2: s = "WHERE";
      3: s = "INSERT";        4: s = "INTO";        5: s = "VALUES";
      6: s = "UPDATE";        7: s = "SET";         8: s = "DELETE";
      9: s = "CREATE";        10: s = "TABLE";      11: s = "ALTER";
      12: s = "ADD";          13: s = "MODIFY";     14: s = "DROP";
      15: s = "TRUNCATE";     16: s = "JOIN";       17: s = "INNER";
      18: s = "LEFT";         19: s = "RIGHT";      20: s = "FULL";
      21: s = "OUTER";        22: s = "CROSS";      23: s = "ON";
      24: s = "BEGIN";        25: s = "COMMIT";     26: s = "ROLLBACK";
      27: s = "INDEX";        28: s = "CONSTRAINT"; 29: s = "PRIMARY";
      30: s = "UNIQUE";       31: s = "NOT";        32: s = "NULL";
      33: s = "FOREIGN";      34: s = "KEY";        35: s = "CHECK";
      36: s = "DEFAULT";      37: s = "ORDER";      38: s = "BY";
      39: s = "ASC";          40: s = "DESC";       41: s = "LIMIT";
      42: s = "OFFSET";       43: s = "AND";        44: s = "OR";
      45: s = "TRUE";         46: s = "FALSE";      47: s = "NOW";
      48: s = {pfx, "DATE"};  49: s = {pfx, "TIME"};
      50: s = {pfx, "TIMESTAMP"};
      51: s = "INT";          52: s = "INTEGER";    53: s = "SMALLINT";
      54: s = "BIGINT";       55: s = "DECIMAL";    56: s = "NUMERIC";
      57: s = "FLOAT";        58: s = "CHAR";       59: s = "VARCHAR";
      60: s = "TEXT";         61: s = "NCHAR";      62: s = "NVARCHAR";
      63: s = "TINYTEXT";     64: s = "MEDIUMTEXT"; 65: s = "LONGTEXT";
      66: s = "ENUM";         67: s = "BOOL";       68: s = "JSON";
      69: s = "DATE";         70: s = "TIME";       71: s = "DATETIME";
      default: s = "TIMESTAMP";
    endcase
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      if (k < s.len()) w[k*8 +: 8] = s[k];
    end
    return w;
  endfunction

  function automatic int kw_len(input int i);
    word_t w;
    int n;
    w = kw_text(i);
    n = 0;
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      if (w[k*8 +: 8] != 8'd0) n = k + 1;
    end
    return n;
  endfunction

  function automatic kind_t kw_kind(input int i);
    kind_t k;
    if (i <= 33)      k = kind_t'(21 + i);
    else if (i == 34) k = kind_t'(50);
    else if (i <= 46) k = kind_t'(20 + i);
    else if (i <= 50) k = K_IDENT;
    else              k = kind_t'(16 + i);
    return k;
  endfunction

  function automatic logic is_space(input char_t c);
    return (c >= 8'd9 && c <= 8'd13) || c == 8'd32 || c == 8'h85 || c == 8'hA0;
  endfunction

  function automatic logic is_alpha(input char_t c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input char_t c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic char_t to_upper(input char_t c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  function automatic kind_t held_kind(input char_t h);
    kind_t k;
    case (h)
      "<":     k = K_LT;
      ">":     k = K_GT;
      "-":     k = K_MINUS;
      default: k = K_UNK;
    endcase
    return k;
  endfunction

  function automatic kind_t single_kind(input char_t c);
    kind_t k;
    case (c)
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      ",":     k = K_COMMA;
      ";":     k = K_SEMI;
      ".":     k = K_DOT;
      "*":     k = K_STAR;
      "%":     k = K_PCT;
      "+":     k = K_PLUS;
      "/":     k = K_SLASH;
      "=":     k = K_EQ;
      default: k = K_UNK;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/sql_token_lexer_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sql_token_lexer_core
// Streaming SQL lexer: one source byte or end marker per item in, token
// records out, up to two records per input item.
// ---------------------------------------------------------------------------
// channel  direction  tdata                          tuser  tlast
// in_      slave      data_byte[7:0]                 mode   -
// out_     master     kind,line,col,span (56 bits)   -      last
//
// Each byte is lexed in the cycle it is accepted; its records land in a
// two-entry result register and the first is offered the next cycle, one
// record goes out per cycle. An item is taken when slot 1 is empty and slot 0
// is empty or being read in the same cycle, so items follow every cycle while
// each gives at most one record; a byte giving two records blocks input until
// the first has left. Reset (rst_n low, synchronous) returns to idle at line 1,
// column 1, no records held; out_tready low with a record held stalls input.
module sql_token_lexer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // kind[6:0], start_line[22:7], start_col[38:23],
                                  // span_length[54:39], zero[55]
  output logic        out_tlast
);

  // lexer state
  stl_pkg::scan_t  state_r, state_nxt;
  stl_pkg::char_t  held_r, held_nxt;
  stl_pkg::char_t  quote_r, quote_nxt;
  logic            esc_r, esc_nxt;
  stl_pkg::word_t  word_r, word_nxt;
  stl_pkg::cnt_t   line_r, line_nxt, col_r, col_nxt;
  stl_pkg::cnt_t   tline_r, tline_nxt, tcol_r, tcol_nxt, tspan_r, tspan_nxt;

  // result register: slot 0 goes out first
  stl_pkg::rec_t   q0_r, q1_r, q0_nxt, q1_nxt;
  logic            ql0_r, ql1_r, ql0_nxt, ql1_nxt;
  stl_pkg::rec_t   ra, rb;

  logic            acc, pop;
  stl_pkg::char_t  c;
  stl_pkg::kind_t  wkind;

  assign c          = in_tdata;
  assign in_tready  = !q1_r.valid && (!q0_r.valid || out_tready);
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = q0_r.valid;
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = {1'b0, q0_r.span, q0_r.col, q0_r.line, q0_r.kind};
  assign out_tlast  = ql0_r;

  // parallel keyword compare on the stored word
  always_comb begin
    wkind = stl_pkg::K_IDENT;
    for (int i = stl_pkg::NUM_KW - 1; i >= 0; i--) begin
      if (tspan_r == stl_pkg::cnt_t'(stl_pkg::kw_len(i))) begin
        if ((word_r & ((stl_pkg::word_t'(1) << (8 * stl_pkg::kw_len(i))) - 1))
            == stl_pkg::kw_text(i))
          wkind = stl_pkg::kw_kind(i);
      end
    end
  end

  // per-byte lexing
  always_comb begin
    logic restart;
    logic idx_ok;
    restart   = 1'b0;
    state_nxt = state_r;
    held_nxt  = held_r;
    quote_nxt = quote_r;
    esc_nxt   = esc_r;
    word_nxt  = word_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    tline_nxt = tline_r;
    tcol_nxt  = tcol_r;
    tspan_nxt = tspan_r;
    ra        = '0;
    rb        = '0;
    idx_ok    = tspan_r < stl_pkg::cnt_t'(stl_pkg::MAX_WORD_LEN);
    if (in_tuser) begin
      // end marker: flush then eof
      case (state_r)
        stl_pkg::ST_IDENT:  ra = '{1'b1, wkind, tline_r, tcol_r, tspan_r};
        stl_pkg::ST_NUMBER: ra = '{1'b1, stl_pkg::K_NUMBER, tline_r, tcol_r, tspan_r};
        stl_pkg::ST_STRING: ra = '{1'b1, stl_pkg::K_STRING, tline_r, tcol_r, tspan_r};
        stl_pkg::ST_HELD:
          ra = '{1'b1, stl_pkg::held_kind(held_r), tline_r, tcol_r, tspan_r};
        default: ra = '0;
      endcase
      rb        = '{1'b1, stl_pkg::K_EOF, line_r, col_r, '0};
      state_nxt = stl_pkg::ST_IDLE;
      tline_nxt = line_r;
      tcol_nxt  = col_r;
      tspan_nxt = '0;
      esc_nxt   = 1'b0;
      line_nxt  = stl_pkg::cnt_t'(1);
      col_nxt   = stl_pkg::cnt_t'(1);
    end else begin
      case (state_r)
        stl_pkg::ST_IDENT: begin
          if (stl_pkg::is_alpha(c) || stl_pkg::is_digit(c)) begin
            if (idx_ok)
              word_nxt[tspan_r[stl_pkg::WIDX_BITS-1:0]*8 +: 8] = stl_pkg::to_upper(c);
            tspan_nxt = stl_pkg::sat_inc(tspan_r);
          end else begin
            ra      = '{1'b1, wkind, tline_r, tcol_r, tspan_r};
            restart = 1'b1;
          end
        end
        stl_pkg::ST_NUMBER: begin
          if (stl_pkg::is_digit(c) || c == ".") tspan_nxt = stl_pkg::sat_inc(tspan_r);
          else begin
            ra      = '{1'b1, stl_pkg::K_NUMBER, tline_r, tcol_r, tspan_r};
            restart = 1'b1;
          end
        end
        stl_pkg::ST_STRING: begin
          tspan_nxt = stl_pkg::sat_inc(tspan_r);
          esc_nxt   = 1'b0;
          if (!(esc_r && c == quote_r)) begin
            if (c == quote_r) begin
              ra        = '{1'b1, stl_pkg::K_STRING, tline_r, tcol_r, tspan_nxt};
              state_nxt = stl_pkg::ST_IDLE;
            end else if (c == "\\") begin
              esc_nxt = 1'b1;
            end
          end
        end
        stl_pkg::ST_HELD: begin
          if (held_r == "-" && c == "-") begin
            state_nxt = stl_pkg::ST_COMMENT;
          end else if (held_r == "<" && (c == "=" || c == ">")) begin
            tspan_nxt = stl_pkg::cnt_t'(2);
            ra = '{1'b1, (c == "=") ? stl_pkg::K_LE : stl_pkg::K_NE, tline_r, tcol_r,
                   stl_pkg::cnt_t'(2)};
            state_nxt = stl_pkg::ST_IDLE;
          end else if ((held_r == ">" || held_r == "!") && c == "=") begin
            tspan_nxt = stl_pkg::cnt_t'(2);
            ra = '{1'b1, (held_r == ">") ? stl_pkg::K_GE : stl_pkg::K_NE, tline_r, tcol_r,
                   stl_pkg::cnt_t'(2)};
            state_nxt = stl_pkg::ST_IDLE;
          end else begin
            ra      = '{1'b1, stl_pkg::held_kind(held_r), tline_r, tcol_r, tspan_r};
            restart = 1'b1;
          end
        end
        stl_pkg::ST_COMMENT: begin
          if (c == 8'd10) state_nxt = stl_pkg::ST_IDLE;
        end
        default: restart = 1'b1;
      endcase
      // start a new token at this byte
      if (restart) begin
        state_nxt = stl_pkg::ST_IDLE;
        tline_nxt = line_r;
        tcol_nxt  = col_r;
        tspan_nxt = stl_pkg::cnt_t'(1);
        if (stl_pkg::is_space(c)) begin
          state_nxt = stl_pkg::ST_IDLE;
        end else if (stl_pkg::is_alpha(c)) begin
          state_nxt       = stl_pkg::ST_IDENT;
          word_nxt[7:0]   = stl_pkg::to_upper(c);
        end else if (stl_pkg::is_digit(c)) begin
          state_nxt = stl_pkg::ST_NUMBER;
        end else if (c == 8'h27 || c == 8'h22) begin
          state_nxt = stl_pkg::ST_STRING;
          quote_nxt = c;
          esc_nxt   = 1'b0;
        end else if (c == "<" || c == ">" || c == "!" || c == "-") begin
          state_nxt = stl_pkg::ST_HELD;
          held_nxt  = c;
        end else begin
          rb = '{1'b1, stl_pkg::single_kind(c), line_r, col_r, stl_pkg::cnt_t'(1)};
        end
      end
      // position
      if (c == 8'd10) begin
        line_nxt = stl_pkg::sat_inc(line_r);
        col_nxt  = stl_pkg::cnt_t'(1);
      end else begin
        col_nxt = stl_pkg::sat_inc(col_r);
      end
    end
  end

  // result register update
  always_comb begin
    stl_pkg::rec_t a, b, s0, s1;
    logic la, lb, l0, l1;
    // compact the new records
    a  = ra.valid ? ra : rb;
    b  = ra.valid ? rb : '0;
    la = !b.valid;
    lb = 1'b1;
    // remove the popped record
    s0 = pop ? q1_r : q0_r;
    l0 = pop ? ql1_r : ql0_r;
    s1 = pop ? '0 : q1_r;
    l1 = pop ? 1'b0 : ql1_r;
    q0_nxt = s0; ql0_nxt = l0;
    q1_nxt = s1; ql1_nxt = l1;
    if (acc && a.valid) begin
      if (!s0.valid) begin
        q0_nxt = a; ql0_nxt = la;
        q1_nxt = b; ql1_nxt = lb;
      end else begin
        q1_nxt = a; ql1_nxt = la;
      end
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stl_pkg::ST_IDLE;
      held_r  <= '0;
      quote_r <= '0;
      esc_r   <= 1'b0;
      line_r  <= stl_pkg::cnt_t'(1);
      col_r   <= stl_pkg::cnt_t'(1);
      tline_r <= stl_pkg::cnt_t'(1);
      tcol_r  <= stl_pkg::cnt_t'(1);
      tspan_r <= '0;
      q0_r    <= '0;
      q1_r    <= '0;
      ql0_r   <= 1'b0;
      ql1_r   <= 1'b0;
    end else begin
      if (acc) begin
        state_r <= state_nxt;
        held_r  <= held_nxt;
        quote_r <= quote_nxt;
        esc_r   <= esc_nxt;
        line_r  <= line_nxt;
        col_r   <= col_nxt;
        tline_r <= tline_nxt;
        tcol_r  <= tcol_nxt;
        tspan_r <= tspan_nxt;
      end
      q0_r  <= q0_nxt;
      q1_r  <= q1_nxt;
      ql0_r <= ql0_nxt;
      ql1_r <= ql1_nxt;
    end
  end

  // word store needs no reset
  always_ff @(posedge clk) begin
    if (acc) word_r <= word_nxt;
  end

endmodule

@@ rtl/stl_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stl_checker
// Port-level checks on the SQL token lexer.
// ---------------------------------------------------------------------------
module stl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast
);

  // stalled record holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("record changed under stall");

  // an accepted end marker with no record held is followed by a record
  a_eof: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser && !out_tvalid |=> out_tvalid)
    else $error("no record after end marker");

  // eof records carry zero span and close the item
  a_eofspan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6:0] == 7'd0 |-> out_tdata[54:39] == 16'd0 && out_tlast)
    else $error("bad eof record");

  // positions never zero
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[22:7] != 16'd0 && out_tdata[38:23] != 16'd0)
    else $error("zero position");

endmodule

bind sql_token_lexer_core stl_checker u_stl_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the SQL token lexer: a directed table of source bytes and end
// markers, then random SQL-like text, with every token record compared
// against a cycle-free predictor of the lexer.
// ---------------------------------------------------------------------------
module testbench;

  localparam int LIMIT_CYCLES = 400000;
  localparam int N_RANDOM     = 850;

  typedef struct {
    logic           mode;
    stl_pkg::char_t ch;
    logic           known;   // expected first record typed in
    stl_pkg::kind_t kind;
    stl_pkg::cnt_t  line;
    stl_pkg::cnt_t  col;
    stl_pkg::cnt_t  span;
  } stim_row_t;

  typedef struct packed {
    stl_pkg::kind_t kind;
    stl_pkg::cnt_t  line;
    stl_pkg::cnt_t  col;
    stl_pkg::cnt_t  span;
    logic           last;
  } token_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tlast;

  sql_token_lexer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // predictor state
  stl_pkg::scan_t lx_state;
  stl_pkg::char_t lx_held;
  stl_pkg::char_t lx_quote;
  logic           lx_escape;
  stl_pkg::char_t lx_word [stl_pkg::MAX_WORD_LEN];
  stl_pkg::cnt_t  lx_line, lx_col, tok_line, tok_col, tok_span;

  // shared prefix of the clock-value keywords
  string  cur_pfx = "CURRENT_";

  token_t pending_tokens[$];
  token_t step_tokens[$];
  int     n_errors;
  int     n_checked;
  int     cycle_count;
  logic   hold_off;
  logic   in_done;

  function automatic stl_pkg::cnt_t bump(stl_pkg::cnt_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic blank(stl_pkg::char_t c);
    return (c >= 8'd9 && c <= 8'd13) || c == 8'd32 || c == 8'h85 || c == 8'hA0;
  endfunction

  function automatic logic letter(stl_pkg::char_t c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic digit(stl_pkg::char_t c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic stl_pkg::char_t upper(stl_pkg::char_t c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic stl_pkg::kind_t lone_kind(stl_pkg::char_t h);
    if (h == "<") return stl_pkg::K_LT;
    if (h == ">") return stl_pkg::K_GT;
    if (h == "-") return stl_pkg::K_MINUS;
    return stl_pkg::K_UNK;
  endfunction

  // keyword lookup over the stored characters
  function automatic stl_pkg::kind_t word_lookup();
    string words [73];
    stl_pkg::kind_t kinds [73];
    string s;
    logic  hit;
    words = '{"SELECT","FROM","WHERE","INSERT","INTO","VALUES","UPDATE","SET",
              "DELETE","CREATE","TABLE","ALTER","ADD","MODIFY","DROP","TRUNCATE",
              "JOIN","INNER","LEFT","RIGHT","FULL","OUTER","CROSS","ON","BEGIN",
              "COMMIT","ROLLBACK","INDEX","CONSTRAINT","PRIMARY","UNIQUE","NOT",
              "NULL","FOREIGN","KEY","CHECK","DEFAULT","ORDER","BY","ASC","DESC",
              "LIMIT","OFFSET","AND","OR","TRUE","FALSE","NOW",{cur_pfx, "DATE"},
              {cur_pfx, "TIME"},{cur_pfx, "TIMESTAMP"},"INT","INTEGER","SMALLINT",
              "BIGINT","DECIMAL","NUMERIC","FLOAT","CHAR","VARCHAR","TEXT","NCHAR",
              "NVARCHAR","TINYTEXT","MEDIUMTEXT","LONGTEXT","ENUM","BOOL","JSON",
              "DATE","TIME","DATETIME","TIMESTAMP"};
    for (int i = 0; i < 73; i++) begin
      if (i <= 33) kinds[i] = stl_pkg::kind_t'(21 + i);
      else if (i == 34) kinds[i] = stl_pkg::kind_t'(50);
      else if (i <= 46) kinds[i] = stl_pkg::kind_t'(20 + i);
      else if (i <= 50) kinds[i] = stl_pkg::K_IDENT;
      else kinds[i] = stl_pkg::kind_t'(16 + i);
    end
    if (tok_span > stl_pkg::MAX_WORD_LEN) return stl_pkg::K_IDENT;
    for (int i = 0; i < 73; i++) begin
      s = words[i];
      if (s.len() == int'(tok_span)) begin
        hit = 1'b1;
        for (int k = 0; k < s.len(); k++)
          if (lx_word[k] != s[k]) hit = 1'b0;
        if (hit) return kinds[i];
      end
    end
    return stl_pkg::K_IDENT;
  endfunction

  function automatic void push_token(stl_pkg::kind_t k);
    token_t t;
    t.kind = k;
    t.line = tok_line;
    t.col  = tok_col;
    t.span = tok_span;
    t.last = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endfunction

  function automatic void open_token(stl_pkg::char_t c);
    lx_state = stl_pkg::ST_IDLE;
    tok_line = lx_line;
    tok_col  = lx_col;
    tok_span = 1;
    if (blank(c)) return;
    if (letter(c)) begin
      lx_state = stl_pkg::ST_IDENT;
      lx_word[0] = upper(c);
    end else if (digit(c)) begin
      lx_state = stl_pkg::ST_NUMBER;
    end else if (c == "'" || c == "\"") begin
      lx_state = stl_pkg::ST_STRING;
      lx_quote = c;
      lx_escape = 1'b0;
    end else if (c == "<" || c == ">" || c == "!" || c == "-") begin
      lx_state = stl_pkg::ST_HELD;
      lx_held = c;
    end else begin
      case (c)
        "(": push_token(stl_pkg::K_LPAREN);
        ")": push_token(stl_pkg::K_RPAREN);
        ",": push_token(stl_pkg::K_COMMA);
        ";": push_token(stl_pkg::K_SEMI);
        ".": push_token(stl_pkg::K_DOT);
        "*": push_token(stl_pkg::K_STAR);
        "%": push_token(stl_pkg::K_PCT);
        "+": push_token(stl_pkg::K_PLUS);
        "/": push_token(stl_pkg::K_SLASH);
        "=": push_token(stl_pkg::K_EQ);
        default: push_token(stl_pkg::K_UNK);
      endcase
    end
  endfunction

  // one input item into the predictor, tokens appended to step_tokens
  function automatic void lex_item(logic mode, stl_pkg::char_t c);
    token_t t;
    step_tokens.delete();
    if (mode) begin
      case (lx_state)
        stl_pkg::ST_IDENT:  push_token(word_lookup());
        stl_pkg::ST_NUMBER: push_token(stl_pkg::K_NUMBER);
        stl_pkg::ST_STRING: push_token(stl_pkg::K_STRING);
        stl_pkg::ST_HELD:   push_token(lone_kind(lx_held));
        default: ;
      endcase
      lx_state = stl_pkg::ST_IDLE;
      tok_line = lx_line;
      tok_col  = lx_col;
      tok_span = 0;
      push_token(stl_pkg::K_EOF);
      lx_escape = 1'b0;
      lx_line = 1;
      lx_col  = 1;
    end else begin
      case (lx_state)
        stl_pkg::ST_IDENT: begin
          if (letter(c) || digit(c)) begin
            if (tok_span < stl_pkg::MAX_WORD_LEN) lx_word[tok_span] = upper(c);
            tok_span = bump(tok_span);
          end else begin
            push_token(word_lookup());
            open_token(c);
          end
        end
        stl_pkg::ST_NUMBER: begin
          if (digit(c) || c == ".") tok_span = bump(tok_span);
          else begin
            push_token(stl_pkg::K_NUMBER);
            open_token(c);
          end
        end
        stl_pkg::ST_STRING: begin
          tok_span = bump(tok_span);
          if (lx_escape && c == lx_quote) lx_escape = 1'b0;
          else begin
            lx_escape = 1'b0;
            if (c == lx_quote) begin
              push_token(stl_pkg::K_STRING);
              lx_state = stl_pkg::ST_IDLE;
            end else if (c == "\\") lx_escape = 1'b1;
          end
        end
        stl_pkg::ST_HELD: begin
          if (lx_held == "-" && c == "-") lx_state = stl_pkg::ST_COMMENT;
          else if (lx_held == "<" && c == "=") begin
            tok_span = 2; push_token(stl_pkg::K_LE); lx_state = stl_pkg::ST_IDLE;
          end else if ((lx_held == "<" && c == ">") || (lx_held == "!" && c == "=")) begin
            tok_span = 2; push_token(stl_pkg::K_NE); lx_state = stl_pkg::ST_IDLE;
          end else if (lx_held == ">" && c == "=") begin
            tok_span = 2; push_token(stl_pkg::K_GE); lx_state = stl_pkg::ST_IDLE;
          end else begin
            push_token(lone_kind(lx_held));
            open_token(c);
          end
        end
        stl_pkg::ST_COMMENT: if (c == "\n") lx_state = stl_pkg::ST_IDLE;
        default: open_token(c);
      endcase
      if (c == "\n") begin
        lx_line = bump(lx_line);
        lx_col = 1;
      end else lx_col = bump(lx_col);
    end
    if (step_tokens.size() > 0) begin
      t = step_tokens[$];
      t.last = 1'b1;
      step_tokens[$] = t;
    end
  endfunction

  // directed table: expected first record typed in where obvious
  stim_row_t directed_rows [] = '{
    '{1'b1, 8'h00, 1'b1, stl_pkg::K_EOF,    16'd1, 16'd1, 16'd0},  // end right after reset
    '{1'b0, "(",   1'b1, stl_pkg::K_LPAREN, 16'd1, 16'd1, 16'd1},
    '{1'b0, 8'hFF, 1'b1, stl_pkg::K_UNK,    16'd1, 16'd2, 16'd1},  // top byte
    '{1'b0, 8'h00, 1'b1, stl_pkg::K_UNK,    16'd1, 16'd3, 16'd1},  // bottom byte
    '{1'b0, 8'hA0, 1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},
    '{1'b0, 8'h85, 1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},
    '{1'b0, "s",   1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},
    '{1'b0, "e",   1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},
    '{1'b0, "t",   1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},
    '{1'b0, "<",   1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},  // keyword then held op
    '{1'b0, ">",   1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},
    '{1'b0, "!",   1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},
    '{1'b0, "x",   1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},  // lone bang
    '{1'b0, "-",   1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},
    '{1'b0, "-",   1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},  // comment
    '{1'b0, "'",   1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},
    '{1'b0, "\n",  1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},
    '{1'b0, "'",   1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},
    '{1'b0, "\\",  1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},
    '{1'b0, "'",   1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},  // escaped quote
    '{1'b0, "\\",  1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},
    '{1'b1, 8'h00, 1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},  // open string at end
    '{1'b0, ">",   1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0},
    '{1'b1, 8'h00, 1'b0, stl_pkg::K_EOF,    16'd0, 16'd0, 16'd0}   // held op at end
  };

  // item queue built up front, sender walks it
  logic           item_mode[$];
  stl_pkg::char_t item_char[$];

  task automatic add_item(logic m, stl_pkg::char_t c);
    item_mode.insert(item_mode.size(), m);
    item_char.insert(item_char.size(), c);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_item(1'b0, s[i]);
  endtask

  // random SQL-like fragments with noise
  task automatic build_random();
    string frags [] = '{"SELECT ", "from ", "Where ", {cur_pfx, "TIMESTAMP "}, "primary ",
                        "Foreign key", {cur_pfx.tolower(), "date"}, "now()", "12.5.3 ",
                        "<=", "<>", "!=", ">=", "< ", "> ", "-- note\n", "'it\\'s'",
                        "\"q\"", "a_very_long_identifier_x ", "timestamp,", "varchar(",
                        ");", "\n", "\t", "_x9 ", "*%+/=.", "-1", "!x", "'\\", "ab17c "};
    int n;
    n = 0;
    while (n < N_RANDOM) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          add_item(1'b0, 8'($urandom_range(0, 255)));
          n++;
        end
        9: if ($urandom_range(0, 3) == 0) begin
          add_item(1'b1, 8'($urandom_range(0, 255)));
          n++;
        end
        default: begin
          string s;
          s = frags[$urandom_range(0, frags.size() - 1)];
          add_text(s);
          n += s.len();
        end
      endcase
    end
    add_item(1'b1, 8'h00);
  endtask

  // sender with random gaps
  initial begin
    int gap;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_done = 1'b0;
    lx_state = stl_pkg::ST_IDLE;
    lx_held = '0;
    lx_quote = '0;
    lx_escape = 1'b0;
    foreach (lx_word[i]) lx_word[i] = '0;
    lx_line = 1; lx_col = 1; tok_line = 1; tok_col = 1; tok_span = 0;
    foreach (directed_rows[i]) add_item(directed_rows[i].mode, directed_rows[i].ch);
    build_random();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < item_mode.size(); i++) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
          : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 2) : 0);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tuser  <= item_mode[i];
      in_tdata  <= item_char[i];
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      lex_item(item_mode[i], item_char[i]);
      if (i < directed_rows.size() && directed_rows[i].known &&
          (step_tokens.size() == 0 || step_tokens[0].kind != directed_rows[i].kind ||
           step_tokens[0].line != directed_rows[i].line ||
           step_tokens[0].col != directed_rows[i].col ||
           step_tokens[0].span != directed_rows[i].span)) begin
        n_errors++;
        if (n_errors <= 10) $display("table row %0d disagrees with predictor", i);
      end
      foreach (step_tokens[k]) pending_tokens.insert(pending_tokens.size(), step_tokens[k]);
    end
    in_tvalid <= 1'b0;
    in_done = 1'b1;
  end

  // receiver stalls, one long hold-off early in the random part
  initial begin
    out_tready = 1'b0;
    hold_off = 1'b0;
    @(posedge rst_n);
    repeat (60) @(posedge clk);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 40) != 0) || !out_tready;
  end

  // compare each accepted record with the oldest expected token
  always @(posedge clk) begin
    token_t exp_tok;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tokens.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected record %h last %b", out_tdata, out_tlast);
      end else begin
        exp_tok = pending_tokens.pop_front();
        n_checked++;
        if (out_tdata[6:0] != exp_tok.kind || out_tdata[22:7] != exp_tok.line ||
            out_tdata[38:23] != exp_tok.col || out_tdata[54:39] != exp_tok.span ||
            out_tdata[55] != 1'b0 || out_tlast != exp_tok.last) begin
          n_errors++;
          if (n_errors <= 10)
            $display({"mismatch: exp kind %0d ln %0d col %0d span %0d last %b, ",
                      "got kind %0d ln %0d col %0d span %0d last %b"},
                     exp_tok.kind, exp_tok.line, exp_tok.col, exp_tok.span, exp_tok.last,
                     out_tdata[6:0], out_tdata[22:7], out_tdata[38:23], out_tdata[54:39],
                     out_tlast);
        end
      end
    end
  end

  // end of run and timeout
  initial begin
    n_errors = 0;
    n_checked = 0;
    cycle_count = 0;
    fork
      begin
        wait (in_done);
        while (pending_tokens.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("%0d source items lexed, %0d token records checked, %0d errors",
                 item_mode.size(), n_checked, n_errors);
        if (n_errors == 0) $display("Verification passed");
        else $display("Verification failed");
      end
      begin
        while (cycle_count < LIMIT_CYCLES) begin
          @(posedge clk);
          cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Verification failed");
      end
    join_any
    $finish;
  end

endmodule
